// ===== sv/tor_pkg.sv =====
// Shared types and constants for the timestamp outlier repair block.
`default_nettype none
package tor_pkg;

  localparam int ShortRun = 2;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_DP_INIT,
    ST_DP_READ,
    ST_DP_CMP,
    ST_DP_STORE,
    ST_BT_READ,
    ST_BT_MARK,
    ST_EM_SCAN,
    ST_EM_FIND,
    ST_EM_DIV,
    ST_EM_OUT
  } tor_state_t;

  typedef struct packed {
    logic load;
    logic dp_init;
    logic dp_read;
    logic dp_cmp;
    logic dp_store;
    logic bt_start;
    logic bt_read;
    logic bt_mark;
    logic em_start;
    logic em_scan;
    logic em_find;
    logic em_div_step;
    logic em_out;
    logic clear;
  } tor_cmd_t;

  typedef struct packed {
    logic j_done;
    logic i_done;
    logic bt_done;
    logic scan_done;
    logic needs_div;
    logic div_done;
    logic k_last;
    logic full;
  } tor_status_t;

endpackage
`default_nettype wire

// ===== sv/timestamp_outlier_repair_top.sv =====
// Top level of the timestamp outlier repair block.
// Loads up to MAX_LEN timestamps (one per cycle while loading, tlast marks the final one),
// finds a longest non-decreasing chain and emits the repaired sequence. The
// chain search compares each entry against every earlier entry in turn, using
// one shared compare unit over the single store read port; each result then
// takes a run scan plus, for runs of three or more, a bit-serial divide.
`default_nettype none
module timestamp_outlier_repair_top
  import tor_pkg::*;
#(
  parameter int MAX_LEN   = 64,
  parameter int TIME_BITS = 20
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [23:0] s_tdata,  // time_value[19:0], zero fill
  input  wire         s_tlast,  // is_final
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [23:0] m_tdata,  // fixed_time[19:0], zero fill
  output logic        m_tlast   // end_of_run
);

  tor_cmd_t    cmd;
  tor_status_t status;
  logic [19:0] fixed;
  logic [TIME_BITS-1:0] tin;

  always_comb begin
    tin = '0;
    for (int b = 0; b < TIME_BITS; b++) begin
      if (b < 20) tin[b] = s_tdata[b];
    end
  end

  tor_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_last  (s_tlast),
    .in_ready (s_tready),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  tor_datapath #(
    .MaxLen  (MAX_LEN),
    .TimeBits(TIME_BITS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .status  (status),
    .in_time (tin),
    .out_time(fixed),
    .out_last(m_tlast)
  );

  assign m_tdata = {4'b0, fixed};

endmodule
`default_nettype wire

// ===== sv/tor_ctrl.sv =====
// Controller state machine for the timestamp outlier repair block.
`default_nettype none
module tor_ctrl
  import tor_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  input  wire         in_last,
  output logic        in_ready,
  output logic        out_valid,
  input  wire         out_ready,
  input  tor_status_t status,
  output tor_cmd_t    cmd
);

  tor_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) begin
            state_next = ST_DP_INIT;
          end
        end
      end
      ST_DP_INIT: begin
        cmd.dp_init = 1'b1;
        state_next  = ST_DP_READ;
      end
      ST_DP_READ: begin
        if (status.j_done) begin
          cmd.dp_store = 1'b1;
          state_next   = ST_DP_STORE;
        end else begin
          cmd.dp_read = 1'b1;
          state_next  = ST_DP_CMP;
        end
      end
      ST_DP_CMP: begin
        cmd.dp_cmp = 1'b1;
        state_next = ST_DP_READ;
      end
      ST_DP_STORE: begin
        if (status.i_done) begin
          cmd.bt_start = 1'b1;
          state_next   = ST_BT_READ;
        end else begin
          cmd.dp_init = 1'b1;
          state_next  = ST_DP_READ;
        end
      end
      ST_BT_READ: begin
        cmd.bt_read = 1'b1;
        state_next  = ST_BT_MARK;
      end
      ST_BT_MARK: begin
        cmd.bt_mark = 1'b1;
        if (status.bt_done) begin
          cmd.em_start = 1'b1;
          state_next   = ST_EM_SCAN;
        end else begin
          state_next = ST_BT_READ;
        end
      end
      ST_EM_SCAN: begin
        cmd.em_scan = 1'b1;
        if (status.scan_done) begin
          state_next = ST_EM_FIND;
        end
      end
      ST_EM_FIND: begin
        cmd.em_find = 1'b1;
        state_next  = ST_EM_DIV;
      end
      ST_EM_DIV: begin
        if (!status.needs_div) begin
          state_next = ST_EM_OUT;
        end else if (status.div_done) begin
          state_next = ST_EM_OUT;
        end else begin
          cmd.em_div_step = 1'b1;
        end
      end
      ST_EM_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.em_out = 1'b1;
          if (status.k_last) begin
            cmd.clear  = 1'b1;
            state_next = ST_LOAD;
          end else begin
            state_next = ST_EM_SCAN;
          end
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/tor_datapath.sv =====
// Datapath: sequence store, chain search, backtrack and run repair.
`default_nettype none
module tor_datapath
  import tor_pkg::*;
#(
  parameter int MaxLen   = 64,
  parameter int TimeBits = 20
) (
  input  wire                 clk,
  input  wire                 rst,
  input  tor_cmd_t            cmd,
  output tor_status_t         status,
  input  wire  [TimeBits-1:0] in_time,
  output logic [19:0]         out_time,
  output logic                out_last
);

  localparam int IdxW = (MaxLen > 1) ? $clog2(MaxLen) : 1;
  localparam int CntW = $clog2(MaxLen + 1);
  localparam int ProdW = TimeBits + CntW;

  logic [TimeBits-1:0] times   [MaxLen];
  logic [CntW-1:0]     lens    [MaxLen];
  logic [IdxW-1:0]     preds   [MaxLen];
  logic [MaxLen-1:0]   normal;

  logic [CntW-1:0] count;
  logic [CntW-1:0] i_cnt, j_cnt, k_cnt;
  logic [TimeBits-1:0] ti, tj;
  logic [CntW-1:0] lj;
  logic [CntW-1:0] cur_len, best_len;
  logic [IdxW-1:0] cur_pred, best_end, bt_idx;
  logic bt_stop;

  // emission scan state
  logic [CntW-1:0] scan, run_start, run_stop;
  logic            have_left_scan, stop_found;
  logic [TimeBits-1:0] left_v, right_v, rd_v;
  logic [TimeBits-1:0] out_v;
  logic                div_active;
  logic [ProdW-1:0]    rem, dvd;
  logic [CntW:0]       divisor;
  logic [ProdW-1:0]    quo;
  logic [CntW-1:0]     div_cnt;

  assign status.full     = (count == CntW'(MaxLen));
  assign status.j_done   = (j_cnt == i_cnt);
  assign status.i_done   = (i_cnt == count);
  assign status.bt_done  = bt_stop;
  assign status.k_last   = (k_cnt + CntW'(1) == count);
  assign status.scan_done = stop_found;
  assign status.needs_div = div_active;
  assign status.div_done  = (div_cnt == '0);

  always_ff @(posedge clk) begin
    if (cmd.load && !status.full) begin
      times[count[IdxW-1:0]] <= in_time;
    end
    if (cmd.dp_store) begin
      lens[i_cnt[IdxW-1:0]]  <= cur_len;
      preds[i_cnt[IdxW-1:0]] <= cur_pred;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      normal <= '0;
    end else begin
      if (cmd.load && !status.full) begin
        count <= count + CntW'(1);
      end
      if (cmd.bt_start) begin
        normal <= '0;
      end
      if (cmd.bt_mark) begin
        normal[bt_idx] <= 1'b1;
      end
      if (cmd.clear) begin
        count  <= '0;
        normal <= '0;
      end
    end
  end

  // chain search and backtrack
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      i_cnt    <= '0;
      best_len <= '0;
      best_end <= '0;
    end
    if (cmd.dp_init) begin
      j_cnt    <= '0;
      cur_len  <= CntW'(1);
      cur_pred <= i_cnt[IdxW-1:0];
      ti       <= times[i_cnt[IdxW-1:0]];
    end
    if (cmd.dp_read) begin
      tj <= times[j_cnt[IdxW-1:0]];
      lj <= lens[j_cnt[IdxW-1:0]];
    end
    if (cmd.dp_cmp) begin
      if (tj <= ti && lj + CntW'(1) > cur_len) begin
        cur_len  <= lj + CntW'(1);
        cur_pred <= j_cnt[IdxW-1:0];
      end
      j_cnt <= j_cnt + CntW'(1);
    end
    if (cmd.dp_store) begin
      if (cur_len > best_len) begin
        best_len <= cur_len;
        best_end <= i_cnt[IdxW-1:0];
      end
      i_cnt <= i_cnt + CntW'(1);
    end
    if (cmd.bt_start) begin
      bt_idx <= best_end;
    end
    if (cmd.bt_read) begin
      cur_pred <= preds[bt_idx];
    end
    if (cmd.bt_mark) begin
      bt_idx <= cur_pred;
    end
  end

  assign bt_stop = (cur_pred == bt_idx) || (CntW'(cur_pred) >= count);

  // repair: per output k, scan right to find run stop, then divide if needed; left tracked incrementally
  always_ff @(posedge clk) begin
    if (cmd.em_start) begin
      k_cnt          <= '0;
      run_start      <= '0;
      have_left_scan <= 1'b0;
      scan           <= '0;
      stop_found     <= 1'b0;
    end
    if (cmd.em_scan && !stop_found) begin
      if (scan == count || normal[scan[IdxW-1:0]]) begin
        stop_found <= 1'b1;
        run_stop   <= scan;
        if (scan != count) begin
          right_v <= times[scan[IdxW-1:0]];
        end
      end else begin
        scan <= scan + CntW'(1);
      end
    end
    if (cmd.em_find) begin
      rd_v       <= times[k_cnt[IdxW-1:0]];
      div_active <= 1'b0;
      div_cnt    <= CntW'(ProdW);
      if (!normal[k_cnt[IdxW-1:0]] && have_left_scan && run_stop != count &&
          (run_stop - run_start) > CntW'(ShortRun) && right_v != left_v) begin
        div_active <= 1'b1;
        dvd     <= ProdW'(right_v - left_v) * ProdW'(k_cnt - run_start + CntW'(1));
        divisor <= (CntW+1)'(run_stop - run_start) + (CntW+1)'(1);
        rem     <= '0;
        quo     <= '0;
      end
    end
    if (cmd.em_div_step) begin
      if ({rem[ProdW-2:0], dvd[ProdW-1]} >= ProdW'(divisor)) begin
        rem <= {rem[ProdW-2:0], dvd[ProdW-1]} - ProdW'(divisor);
        quo <= {quo[ProdW-2:0], 1'b1};
      end else begin
        rem <= {rem[ProdW-2:0], dvd[ProdW-1]};
        quo <= {quo[ProdW-2:0], 1'b0};
      end
      dvd     <= {dvd[ProdW-2:0], 1'b0};
      div_cnt <= div_cnt - CntW'(1);
    end
    if (cmd.em_out) begin
      k_cnt <= k_cnt + CntW'(1);
      if (normal[k_cnt[IdxW-1:0]]) begin
        have_left_scan <= 1'b1;
        left_v         <= rd_v;
        run_start      <= k_cnt + CntW'(1);
        scan           <= k_cnt + CntW'(1);
        stop_found     <= 1'b0;
      end
    end
  end

  always_comb begin
    logic [CntW-1:0] dl, dr;
    dl = k_cnt - run_start + CntW'(1);
    dr = run_stop - k_cnt;
    if (normal[k_cnt[IdxW-1:0]]) begin
      out_v = rd_v;
    end else if (!have_left_scan) begin
      out_v = right_v;
    end else if (run_stop == count) begin
      out_v = left_v;
    end else if ((run_stop - run_start) <= CntW'(ShortRun)) begin
      out_v = (dl <= dr) ? left_v : right_v;
    end else if (div_active) begin
      out_v = left_v + quo[TimeBits-1:0];
    end else begin
      out_v = left_v;
    end
  end

  assign out_time = 20'(out_v);
  assign out_last = status.k_last;

endmodule
`default_nettype wire

// ===== sim/timestamp_outlier_repair_top_test.sv =====
// Self-checking testbench for the timestamp outlier repair block.
`default_nettype none
module timestamp_outlier_repair_top_test;

  localparam int MaxLen = 64;
  localparam int ShortRunLen = 2;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tlast;

  timestamp_outlier_repair_top DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [19:0] seq_times[MaxLen];
  int          seq_count;
  logic [19:0] want_time_q[$];
  logic        want_last_q[$];
  int          fail_count;
  int          sent_count;
  int          seq_done;
  bit          idle_en;

  // chain search and run repair for the current sequence
  task automatic repair_sequence();
    int          clen[MaxLen];
    int          pred[MaxLen];
    bit          normal[MaxLen];
    int          best_len;
    int          best_end;
    int          idx;
    int          lo;
    int          hi;
    int          cnt;
    longint      lft;
    longint      rgt;
    logic [19:0] val;
    logic        last_flag;
    best_len = 0;
    best_end = 0;
    for (int i = 0; i < seq_count; i++) begin
      clen[i] = 1;
      pred[i] = i;
      normal[i] = 1'b0;
      for (int j = 0; j < i; j++) begin
        if (seq_times[j] <= seq_times[i] && clen[j] + 1 > clen[i]) begin
          clen[i] = clen[j] + 1;
          pred[i] = j;
        end
      end
      if (clen[i] > best_len) begin
        best_len = clen[i];
        best_end = i;
      end
    end
    idx = best_end;
    for (int g = 0; g < MaxLen; g++) begin
      normal[idx] = 1'b1;
      if (pred[idx] == idx) break;
      idx = pred[idx];
    end
    for (int k = 0; k < seq_count; k++) begin
      if (normal[k]) begin
        val = seq_times[k];
      end else begin
        lo = k;
        hi = k;
        while (lo > 0 && !normal[lo-1]) lo--;
        while (hi < seq_count && !normal[hi]) hi++;
        cnt = hi - lo;
        lft = (lo > 0) ? longint'(seq_times[lo-1]) : 64'sd0;
        rgt = (hi < seq_count) ? longint'(seq_times[hi]) : 64'sd0;
        if (lo == 0) val = 20'(rgt);
        else if (hi == seq_count) val = 20'(lft);
        else if (cnt <= ShortRunLen) val = ((k - lo + 1) <= (hi - k)) ? 20'(lft) : 20'(rgt);
        else val = 20'(lft + (rgt - lft) * (k - lo + 1) / (cnt + 1));
      end
      last_flag = (k + 1 == seq_count);
      want_time_q = {want_time_q, val};
      want_last_q = {want_last_q, last_flag};
    end
    seq_count = 0;
  endtask

  task automatic send_item(input logic [19:0] tv, input bit fin);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'b0, tv};
    s_tlast <= fin;
    do @(posedge clk); while (!s_tready);
    sent_count++;
    if (seq_count < MaxLen) begin
      seq_times[seq_count] = tv;
      seq_count++;
    end
    if (fin) begin
      repair_sequence();
      seq_done++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (want_time_q.size() == 0) begin
        $error("unexpected result fixed_time=%0h", m_tdata[19:0]);
        fail_count++;
      end else begin
        if (m_tdata !== {4'b0, want_time_q[0]}) begin
          $error("fixed_time expected %0h actual %0h", want_time_q[0], m_tdata);
          fail_count++;
        end
        if (m_tlast !== want_last_q[0]) begin
          $error("end_of_run expected %0b actual %0b", want_last_q[0], m_tlast);
          fail_count++;
        end
        void'(want_time_q.pop_front());
        void'(want_last_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (idle_en && $urandom_range(0, 5) == 0) begin
      m_tready <= 1'b0;
      repeat ($urandom_range(1, 8) - 1) @(posedge clk);
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic send_list(input logic [19:0] vals[$]);
    foreach (vals[i]) send_item(vals[i], i == vals.size() - 1);
  endtask

  task automatic wait_drained();
    while (want_time_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_list('{20'h00000});
    send_list('{20'hFFFFF, 20'h00000});
    send_list('{20'd10, 20'd500, 20'd20});
    send_list('{20'd10, 20'd900, 20'd800, 20'd40});
    send_list('{20'd100, 20'd5, 20'd6, 20'd7, 20'd400});
    send_list('{20'd900, 20'd800, 20'd50, 20'd60});
    send_list('{20'd0, 20'd1, 20'hFFFFF, 20'hFFFFE});
    send_list('{20'd5, 20'd5, 20'd5});
  endtask

  task automatic test_overflow();
    for (int i = 0; i < MaxLen + 3; i++)
      send_item(i[19:0] ^ (i % 7 == 3 ? 20'hAAAAA : 20'h0), i == MaxLen + 2);
  endtask

  task automatic test_random(input int items);
    int n;
    int kind;
    logic [19:0] base;
    logic [19:0] tv;
    while (sent_count < items) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, MaxLen) : $urandom_range(1, 12);
      kind = $urandom_range(0, 3);
      base = 20'($urandom_range(0, 1000));
      for (int i = 0; i < n; i++) begin
        if (kind == 0) tv = 20'($urandom);
        else if ($urandom_range(0, 4) == 0) tv = 20'($urandom);
        else begin
          base = base + 20'($urandom_range(0, (kind == 3) ? 32'hFFFF : 32'd200));
          tv = base;
        end
        send_item(tv, i == n - 1);
      end
    end
  endtask

  initial begin
    fail_count = 0;
    sent_count = 0;
    seq_count = 0;
    seq_done = 0;
    idle_en = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_overflow();
    test_random(330);
    idle_en = 1'b0;
    test_random(420);
    s_tvalid <= 1'b0;
    wait_drained();
    repeat (200) @(posedge clk);
    $display("Sent %0d timestamps in %0d sequences: edge values, overflow, random runs.",
             sent_count, seq_done);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("FAIL");
    $finish;
  end

endmodule
`default_nettype wire
